### rtl/core/tsp_pkg.sv
// Shared types and constants for the Thole-screened pair energy pipeline.
`timescale 1ns / 1ps

package tsp_pkg;

  // One input word: two positions, two charges, radius and Thole factor.
  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic signed [31:0] first_charge;
    logic signed [31:0] second_charge;
    logic        [30:0] alpha_radius;
    logic        [30:0] thole_factor;
  } tsp_in_t;

  // One result word.
  typedef struct packed {
    logic signed [47:0] pair_energy;
    logic               coincident;
    logic               saturated;
  } tsp_out_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_BOX_X = 2'd0,
    CFG_BOX_Y = 2'd1,
    CFG_BOX_Z = 2'd2,
    CFG_SCALE = 2'd3
  } tsp_cfg_idx_t;

  localparam logic [30:0] SCALE_RESET = 31'd9105274;

  // Width of the screening ratio u that reaches the exponential.
  localparam int EXP_U_W = 22;
  // Number of Taylor terms and of repeated squarings in the exponential.
  localparam int EXP_TERMS   = 13;
  localparam int EXP_SQUARES = 6;

  // 1.0 in Q0.31 and the cutoff 50.0 in Q16.16.
  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
  localparam logic [22:0] U_LIMIT = 23'd3276800;

endpackage

### rtl/core/tsp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`timescale 1ns / 1ps

module tsp_div import tsp_pkg::*; #(
  parameter int NUM_W  = 64,
  parameter int DEN_W  = 32,
  parameter int QUO_W  = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [QUO_W-1:0]  quo,
  output logic [DEN_W-1:0]  rem,
  output logic              ovf,
  output logic [SIDE_W-1:0] side_out
);

  localparam int HI_W  = NUM_W - QUO_W;
  localparam int CMP_W = HI_W + DEN_W;

  logic              vld_r  [0:QUO_W];
  logic [DEN_W-1:0]  rem_r  [0:QUO_W];
  // Low numerator bits shift out at the top while quotient bits shift in.
  logic [QUO_W-1:0]  qs_r   [0:QUO_W];
  logic [DEN_W-1:0]  den_r  [0:QUO_W];
  logic              ovf_r  [0:QUO_W];
  logic [SIDE_W-1:0] side_r [0:QUO_W];

  logic [HI_W-1:0] num_hi;
  logic            ovf_nxt;

  // The quotient does not fit when the upper numerator part reaches the divisor.
  assign num_hi  = num[NUM_W-1:QUO_W];
  assign ovf_nxt = CMP_W'(num_hi) >= CMP_W'(den);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= DEN_W'(num_hi);
      qs_r[0]   <= num[QUO_W-1:0];
      den_r[0]  <= den;
      ovf_r[0]  <= ovf_nxt;
      side_r[0] <= side_in;
    end
  end

  // One trial subtraction per stage.
  for (genvar s = 1; s <= QUO_W; s++) begin : g_step
    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    assign trial = {rem_r[s-1], qs_r[s-1][QUO_W-1]};
    assign diff  = trial - {1'b0, den_r[s-1]};
    assign ge    = trial >= {1'b0, den_r[s-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        qs_r[s]   <= {qs_r[s-1][QUO_W-2:0], ge};
        den_r[s]  <= den_r[s-1];
        ovf_r[s]  <= ovf_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign out_valid = vld_r[QUO_W];
  assign quo       = qs_r[QUO_W];
  assign rem       = rem_r[QUO_W];
  assign ovf       = ovf_r[QUO_W];
  assign side_out  = side_r[QUO_W];

endmodule

### rtl/core/tsp_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps

module tsp_sqrt import tsp_pkg::*; #(
  parameter int RAD_W  = 66,
  parameter int SIDE_W = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [RAD_W-1:0]           rad,
  input  logic [SIDE_W-1:0]          side_in,
  output logic                       out_valid,
  output logic [(RAD_W+1)/2-1:0]     root,
  output logic [SIDE_W-1:0]          side_out
);

  localparam int STEPS = (RAD_W + 1) / 2;
  localparam int PAD_W = 2 * STEPS;

  logic              vld_r  [0:STEPS];
  logic [PAD_W-1:0]  rad_r  [0:STEPS];
  logic [STEPS+1:0]  rem_r  [0:STEPS];
  logic [STEPS-1:0]  root_r [0:STEPS];
  logic [SIDE_W-1:0] side_r [0:STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= PAD_W'(rad);
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      side_r[0] <= side_in;
    end
  end

  // Each stage brings down the next bit pair and tries (4*root + 1).
  for (genvar s = 1; s <= STEPS; s++) begin : g_step
    logic [STEPS+1:0] rem_sh;
    logic [STEPS+1:0] trial;
    logic             ge;

    assign rem_sh = {rem_r[s-1][STEPS-1:0], rad_r[s-1][PAD_W-2*s+1 -: 2]};
    assign trial  = {root_r[s-1], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[s]  <= rad_r[s-1];
        rem_r[s]  <= ge ? (rem_sh - trial) : rem_sh;
        root_r[s] <= {root_r[s-1][STEPS-2:0], ge};
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign out_valid = vld_r[STEPS];
  assign root      = root_r[STEPS];
  assign side_out  = side_r[STEPS];

endmodule

### rtl/core/tsp_exp.sv
// Pipelined exp(-u): Taylor series of exp(-u/64) followed by six squarings.
`timescale 1ns / 1ps

module tsp_exp import tsp_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [EXP_U_W-1:0] u,
  input  logic [SIDE_W-1:0]  side_in,
  output logic               out_valid,
  output logic [31:0]        e_out,
  output logic [SIDE_W-1:0]  side_out
);

  // Per-term results; index n holds the state after term n.
  logic               lv_r    [1:EXP_TERMS];
  logic [30:0]        lt_r    [1:EXP_TERMS];
  logic [31:0]        lterm_r [1:EXP_TERMS];
  logic signed [33:0] lsum_r  [1:EXP_TERMS];
  logic [SIDE_W-1:0]  lside_r [1:EXP_TERMS];

  logic [30:0]        t_nxt;
  logic signed [33:0] sum_nxt;

  // First term: t itself, so the sum starts at 1 - t.
  assign t_nxt   = {u, 9'b0};
  assign sum_nxt = $signed({2'b00, ONE_Q31}) - $signed({3'b000, t_nxt});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lv_r[1] <= 1'b0;
    end else if (en) begin
      lv_r[1] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lt_r[1]    <= t_nxt;
      lterm_r[1] <= {1'b0, t_nxt};
      lsum_r[1]  <= sum_nxt;
      lside_r[1] <= side_in;
    end
  end

  // Terms two and up take three stages: multiply, reciprocal, correct and sum.
  for (genvar n = 2; n <= EXP_TERMS; n++) begin : g_term
    localparam logic [32:0] RECIP = 33'((65'd1 << 33) / n);

    logic               a_vld_r, b_vld_r;
    logic [30:0]        a_t_r, b_t_r;
    logic [31:0]        a_x_r, b_x_r, b_qd_r;
    logic signed [33:0] a_sum_r, b_sum_r;
    logic [SIDE_W-1:0]  a_side_r, b_side_r;

    logic [62:0] mul;
    logic [64:0] rp;
    logic [35:0] chk;
    logic        fix;
    logic [31:0] q;

    assign mul = 63'(lterm_r[n-1]) * 63'(lt_r[n-1]);
    assign rp  = 65'(a_x_r) * 65'(RECIP);
    // The reciprocal estimate is low by at most one.
    assign chk = 36'(b_x_r) - 36'(b_qd_r) * 36'(n);
    assign fix = chk >= 36'(n);
    assign q   = b_qd_r + 32'(fix);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        a_vld_r <= 1'b0;
        b_vld_r <= 1'b0;
        lv_r[n] <= 1'b0;
      end else if (en) begin
        a_vld_r <= lv_r[n-1];
        b_vld_r <= a_vld_r;
        lv_r[n] <= b_vld_r;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_t_r      <= lt_r[n-1];
        a_x_r      <= mul[62:31];
        a_sum_r    <= lsum_r[n-1];
        a_side_r   <= lside_r[n-1];
        b_t_r      <= a_t_r;
        b_x_r      <= a_x_r;
        b_qd_r     <= rp[64:33];
        b_sum_r    <= a_sum_r;
        b_side_r   <= a_side_r;
        lt_r[n]    <= b_t_r;
        lterm_r[n] <= q;
        lside_r[n] <= b_side_r;
        if (n % 2 == 1) begin
          lsum_r[n] <= b_sum_r - $signed({2'b00, q});
        end else begin
          lsum_r[n] <= b_sum_r + $signed({2'b00, q});
        end
      end
    end
  end

  // Clamp the series sum to [0, 1] ahead of the squaring chain.
  logic [31:0] clamp;

  always_comb begin
    if (lsum_r[EXP_TERMS][33]) begin
      clamp = '0;
    end else if (lsum_r[EXP_TERMS] > $signed({2'b00, ONE_Q31})) begin
      clamp = ONE_Q31;
    end else begin
      clamp = lsum_r[EXP_TERMS][31:0];
    end
  end

  logic              sq_vld_r  [1:EXP_SQUARES];
  logic [31:0]       sq_r      [1:EXP_SQUARES];
  logic [SIDE_W-1:0] sq_side_r [1:EXP_SQUARES];
  logic              sq_vld_src  [1:EXP_SQUARES];
  logic [31:0]       sq_src      [1:EXP_SQUARES];
  logic [SIDE_W-1:0] sq_side_src [1:EXP_SQUARES];

  assign sq_vld_src[1]  = lv_r[EXP_TERMS];
  assign sq_src[1]      = clamp;
  assign sq_side_src[1] = lside_r[EXP_TERMS];

  // Six squarings raise exp(-u/64) to exp(-u).
  for (genvar k = 1; k <= EXP_SQUARES; k++) begin : g_square
    logic [63:0] sq;

    if (k > 1) begin : g_link
      assign sq_vld_src[k]  = sq_vld_r[k-1];
      assign sq_src[k]      = sq_r[k-1];
      assign sq_side_src[k] = sq_side_r[k-1];
    end

    assign sq = 64'(sq_src[k]) * 64'(sq_src[k]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k] <= 1'b0;
      end else if (en) begin
        sq_vld_r[k] <= sq_vld_src[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k]      <= sq[62:31];
        sq_side_r[k] <= sq_side_src[k];
      end
    end
  end

  assign out_valid = sq_vld_r[EXP_SQUARES];
  assign e_out     = sq_r[EXP_SQUARES];
  assign side_out  = sq_side_r[EXP_SQUARES];

endmodule

### rtl/core/thole_screened_pair_energy.sv
// Throughput: one pair per cycle while the output is not stalled.
// Every stage is a register stage under one shared enable.
// Latency is set mostly by the one-bit-per-stage dividers (wrap, ratio, energy), the square root and the exponential.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Synchronous active-low reset clears all valid bits and loads the register defaults.
`timescale 1ns / 1ps

module thole_screened_pair_energy import tsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  tsp_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output tsp_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_wdata
);

  typedef struct packed {
    logic signed [31:0] charge_a;
    logic signed [31:0] charge_b;
    logic [30:0]        alpha;
    logic [30:0]        thole;
  } tsp_pair_t;

  typedef struct packed {
    logic [31:0] mag_x;
    logic [31:0] mag_y;
    logic [31:0] mag_z;
    tsp_pair_t   pair;
  } tsp_wrap_side_t;

  typedef struct packed {
    tsp_pair_t pair;
    logic      coin;
  } tsp_root_side_t;

  typedef struct packed {
    logic signed [31:0] charge_a;
    logic signed [31:0] charge_b;
    logic               coin;
    logic [32:0]        sep;
  } tsp_ratio_side_t;

  typedef struct packed {
    tsp_ratio_side_t       base;
    logic [EXP_U_W-1:0]    u;
    logic                  big;
  } tsp_exp_side_t;

  typedef struct packed {
    logic neg;
    logic coin;
  } tsp_fin_side_t;

  // Magnitude of a 33-bit signed difference.
  function automatic logic [31:0] mag33(input logic [32:0] d);
    logic [32:0] m;
    m = d[32] ? (~d + 33'd1) : d;
    return m[31:0];
  endfunction

  // Minimum-image magnitude from the divider remainder of (2m + L) / 2L.
  function automatic logic [31:0] wrap_mag(input logic [31:0] rem, input logic [30:0] len,
                                           input logic [31:0] mag);
    logic [32:0] diff;
    logic [32:0] am;
    diff = {1'b0, rem} - {2'b00, len};
    am   = diff[32] ? (~diff + 33'd1) : diff;
    return (len == '0) ? mag : am[32:1];
  endfunction

  logic adv;

  // The pipeline moves whenever the output register can take a word.
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Configuration registers.
  logic [30:0] box_x_r, box_y_r, box_z_r, scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r <= '0;
      box_y_r <= '0;
      box_z_r <= '0;
      scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BOX_X: box_x_r <= cfg_wdata;
        CFG_BOX_Y: box_y_r <= cfg_wdata;
        CFG_BOX_Z: box_z_r <= cfg_wdata;
        CFG_SCALE: scale_r <= cfg_wdata;
        default:   box_x_r <= box_x_r;
      endcase
    end
  end

  // Stage A: input register.
  logic    a_vld_r;
  tsp_in_t a_in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_in_r <= in_data;
    end
  end

  // Stage B: displacement magnitudes per axis.
  tsp_wrap_side_t b_side_nxt, b_side_r;
  logic           b_vld_r;

  assign b_side_nxt.mag_x = mag33({a_in_r.first_x[31], a_in_r.first_x}
                                  - {a_in_r.second_x[31], a_in_r.second_x});
  assign b_side_nxt.mag_y = mag33({a_in_r.first_y[31], a_in_r.first_y}
                                  - {a_in_r.second_y[31], a_in_r.second_y});
  assign b_side_nxt.mag_z = mag33({a_in_r.first_z[31], a_in_r.first_z}
                                  - {a_in_r.second_z[31], a_in_r.second_z});
  assign b_side_nxt.pair.charge_a = a_in_r.first_charge;
  assign b_side_nxt.pair.charge_b = a_in_r.second_charge;
  assign b_side_nxt.pair.alpha    = a_in_r.alpha_radius;
  assign b_side_nxt.pair.thole    = a_in_r.thole_factor;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_side_r <= b_side_nxt;
    end
  end

  // Image count dividers, one per axis; only the remainder is needed.
  logic [33:0] num_x, num_y, num_z;
  logic [31:0] w_rem_x, w_rem_y, w_rem_z;
  logic [$bits(tsp_wrap_side_t)-1:0] w_side_vec;
  tsp_wrap_side_t w_side;
  logic        w_vld;

  assign num_x = {1'b0, b_side_r.mag_x, 1'b0} + {3'b000, box_x_r};
  assign num_y = {1'b0, b_side_r.mag_y, 1'b0} + {3'b000, box_y_r};
  assign num_z = {1'b0, b_side_r.mag_z, 1'b0} + {3'b000, box_z_r};

  tsp_div #(.NUM_W(34), .DEN_W(32), .QUO_W(33), .SIDE_W($bits(tsp_wrap_side_t))) u_wrap_x (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(b_vld_r),
    .num(num_x), .den({box_x_r, 1'b0}), .side_in(b_side_r),
    .out_valid(w_vld), .quo(), .rem(w_rem_x), .ovf(), .side_out(w_side_vec)
  );

  tsp_div #(.NUM_W(34), .DEN_W(32), .QUO_W(33), .SIDE_W(1)) u_wrap_y (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(b_vld_r),
    .num(num_y), .den({box_y_r, 1'b0}), .side_in(1'b0),
    .out_valid(), .quo(), .rem(w_rem_y), .ovf(), .side_out()
  );

  tsp_div #(.NUM_W(34), .DEN_W(32), .QUO_W(33), .SIDE_W(1)) u_wrap_z (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(b_vld_r),
    .num(num_z), .den({box_z_r, 1'b0}), .side_in(1'b0),
    .out_valid(), .quo(), .rem(w_rem_z), .ovf(), .side_out()
  );

  assign w_side = tsp_wrap_side_t'(w_side_vec);

  // Stage C: wrapped magnitudes.
  logic        c_vld_r;
  logic [31:0] c_x_r, c_y_r, c_z_r;
  tsp_pair_t   c_pair_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= w_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_x_r    <= wrap_mag(w_rem_x, box_x_r, w_side.mag_x);
      c_y_r    <= wrap_mag(w_rem_y, box_y_r, w_side.mag_y);
      c_z_r    <= wrap_mag(w_rem_z, box_z_r, w_side.mag_z);
      c_pair_r <= w_side.pair;
    end
  end

  // Stage D: squares; stage E: Q32.32 sum of squares.
  logic        d_vld_r, e_vld_r;
  logic [63:0] d_sx_r, d_sy_r, d_sz_r;
  logic [65:0] e_sum_r;
  tsp_pair_t   d_pair_r, e_pair_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
    end else if (adv) begin
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_sx_r   <= 64'(c_x_r) * 64'(c_x_r);
      d_sy_r   <= 64'(c_y_r) * 64'(c_y_r);
      d_sz_r   <= 64'(c_z_r) * 64'(c_z_r);
      d_pair_r <= c_pair_r;
      e_sum_r  <= 66'(d_sx_r) + 66'(d_sy_r) + 66'(d_sz_r);
      e_pair_r <= d_pair_r;
    end
  end

  // Distance root; a zero sum marks a coincident pair.
  tsp_root_side_t s_side_in, s_side;
  logic [$bits(tsp_root_side_t)-1:0] s_side_vec;
  logic [32:0] s_root;
  logic        s_vld;

  assign s_side_in.pair = e_pair_r;
  assign s_side_in.coin = (e_sum_r == '0);

  tsp_sqrt #(.RAD_W(66), .SIDE_W($bits(tsp_root_side_t))) u_root (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(e_vld_r),
    .rad(e_sum_r), .side_in(s_side_in),
    .out_valid(s_vld), .root(s_root), .side_out(s_side_vec)
  );

  assign s_side = tsp_root_side_t'(s_side_vec);

  // Stage F: thole * r and the guarded radius.
  logic            f_vld_r;
  logic [63:0]     f_prod_r;
  logic [30:0]     f_alpha_r;
  tsp_ratio_side_t f_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (adv) begin
      f_vld_r <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_prod_r          <= 64'(s_side.pair.thole) * 64'(s_root);
      f_alpha_r         <= (s_side.pair.alpha == '0) ? 31'd1 : s_side.pair.alpha;
      f_side_r.charge_a <= s_side.pair.charge_a;
      f_side_r.charge_b <= s_side.pair.charge_b;
      f_side_r.coin     <= s_side.coin;
      f_side_r.sep      <= s_root;
    end
  end

  // Ratio u = thole * r / alpha; an overflowed quotient is past the cutoff.
  logic [22:0] r_quo;
  logic        r_ovf, r_vld;
  logic [$bits(tsp_ratio_side_t)-1:0] r_side_vec;
  tsp_exp_side_t x_side_in, x_side;
  logic [$bits(tsp_exp_side_t)-1:0] x_side_vec;
  logic [31:0] x_e;
  logic        x_vld;

  tsp_div #(.NUM_W(64), .DEN_W(31), .QUO_W(23), .SIDE_W($bits(tsp_ratio_side_t))) u_ratio (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(f_vld_r),
    .num(f_prod_r), .den(f_alpha_r), .side_in(f_side_r),
    .out_valid(r_vld), .quo(r_quo), .rem(), .ovf(r_ovf), .side_out(r_side_vec)
  );

  assign x_side_in.base = tsp_ratio_side_t'(r_side_vec);
  assign x_side_in.u    = r_quo[EXP_U_W-1:0];
  assign x_side_in.big  = r_ovf || (r_quo > U_LIMIT);

  tsp_exp #(.SIDE_W($bits(tsp_exp_side_t))) u_exp (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(r_vld),
    .u(r_quo[EXP_U_W-1:0]), .side_in(x_side_in),
    .out_valid(x_vld), .e_out(x_e), .side_out(x_side_vec)
  );

  assign x_side = tsp_exp_side_t'(x_side_vec);

  // Stage G: screening S1 = 1 - e * (1 + u/2), or exactly 1 past the cutoff.
  logic [54:0] p_full;
  logic [37:0] p_raw;
  logic [31:0] p_clamp;

  assign p_full  = 55'(x_e) * 55'(23'h20000 + 23'(x_side.u));
  assign p_raw   = p_full[54:17];
  assign p_clamp = (p_raw > 38'(ONE_Q31)) ? ONE_Q31 : p_raw[31:0];

  logic            g_vld_r;
  logic [31:0]     g_s1_r;
  tsp_ratio_side_t g_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_vld_r <= 1'b0;
    end else if (adv) begin
      g_vld_r <= x_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_s1_r   <= x_side.big ? ONE_Q31 : (ONE_Q31 - p_clamp);
      g_side_r <= x_side.base;
    end
  end

  // Stage H: charge product and scale times S1.
  logic          h_vld_r;
  logic [63:0]   h_m1_r;
  logic [62:0]   h_m2_r;
  logic [32:0]   h_dist_r;
  tsp_fin_side_t h_side_r;
  logic [31:0]   qa, qb;

  assign qa = mag33({g_side_r.charge_a[31], g_side_r.charge_a});
  assign qb = mag33({g_side_r.charge_b[31], g_side_r.charge_b});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_vld_r <= 1'b0;
    end else if (adv) begin
      h_vld_r <= g_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_m1_r        <= 64'(qa) * 64'(qb);
      h_m2_r        <= 63'(scale_r) * 63'(g_s1_r);
      h_dist_r      <= g_side_r.sep;
      h_side_r.neg  <= g_side_r.charge_a[31] != g_side_r.charge_b[31];
      h_side_r.coin <= g_side_r.coin;
    end
  end

  // Stage I: four 32x32 partial products of m1 * m2.
  logic          i_vld_r;
  logic [63:0]   i_pp00_r, i_pp01_r, i_pp10_r, i_pp11_r;
  logic [32:0]   i_dist_r;
  tsp_fin_side_t i_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_vld_r <= 1'b0;
    end else if (adv) begin
      i_vld_r <= h_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_pp00_r <= 64'(h_m1_r[31:0])  * 64'(h_m2_r[31:0]);
      i_pp01_r <= 64'(h_m1_r[31:0])  * 64'(h_m2_r[62:32]);
      i_pp10_r <= 64'(h_m1_r[63:32]) * 64'(h_m2_r[31:0]);
      i_pp11_r <= 64'(h_m1_r[63:32]) * 64'(h_m2_r[62:32]);
      i_dist_r <= h_dist_r;
      i_side_r <= h_side_r;
    end
  end

  // Stage J: full product, scaled down by 2^47.
  logic [127:0]  prod_full;
  logic          j_vld_r;
  logic [77:0]   j_num_r;
  logic [32:0]   j_dist_r;
  tsp_fin_side_t j_side_r;

  assign prod_full = {i_pp11_r, 64'b0} + {32'b0, i_pp01_r, 32'b0}
                   + {32'b0, i_pp10_r, 32'b0} + {64'b0, i_pp00_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_vld_r <= 1'b0;
    end else if (adv) begin
      j_vld_r <= i_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j_num_r  <= prod_full[124:47];
      j_dist_r <= i_dist_r;
      j_side_r <= i_side_r;
    end
  end

  // Energy magnitude divided by r; quotients of 2^49 or more only flag overflow.
  logic [48:0] q_quo;
  logic        q_ovf, q_vld;
  logic [$bits(tsp_fin_side_t)-1:0] q_side_vec;
  tsp_fin_side_t q_side;

  tsp_div #(.NUM_W(78), .DEN_W(33), .QUO_W(49), .SIDE_W($bits(tsp_fin_side_t))) u_energy (
    .clk(clk), .rst_n(rst_n), .en(adv), .in_valid(j_vld_r),
    .num(j_num_r), .den(j_dist_r), .side_in(j_side_r),
    .out_valid(q_vld), .quo(q_quo), .rem(), .ovf(q_ovf), .side_out(q_side_vec)
  );

  assign q_side = tsp_fin_side_t'(q_side_vec);

  // Saturate, apply the sign and handle the coincident pair.
  logic     sat;
  logic [47:0] mag;
  tsp_out_t out_nxt;

  always_comb begin
    if (q_side.neg) begin
      sat = q_ovf || (q_quo > 49'h0_8000_0000_0000);
      mag = sat ? 48'h8000_0000_0000 : q_quo[47:0];
    end else begin
      sat = q_ovf || (q_quo > 49'h0_7FFF_FFFF_FFFF);
      mag = sat ? 48'h7FFF_FFFF_FFFF : q_quo[47:0];
    end
    if (q_side.coin) begin
      out_nxt.pair_energy = '0;
      out_nxt.coincident  = 1'b1;
      out_nxt.saturated   = 1'b0;
    end else begin
      out_nxt.pair_energy = q_side.neg ? $signed(48'd0 - mag) : $signed(mag);
      out_nxt.coincident  = 1'b0;
      out_nxt.saturated   = sat;
    end
  end

  // Output register.
  logic     out_valid_r;
  tsp_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
